### sv/bcg_pkg.sv
package bcg_pkg;

  localparam int unsigned VOLT_W = 15;
  localparam int unsigned PCT_W  = 7;

  localparam int unsigned VOLT_FRAC_BITS_DEF = 10;
  localparam int unsigned COEF_FRAC_BITS_DEF = 24;

  // floor(x / 5) == (x * FILT_RECIP) >> FILT_SHIFT for x < 2^FILT_W
  localparam int unsigned FILT_W     = 18;
  localparam int unsigned RECIP_W    = 19;
  localparam int unsigned FILT_RECIP = 419431;
  localparam int unsigned FILT_SHIFT = 21;

  // Integer bits above the coefficient fraction held by the Horner accumulator
  localparam int unsigned ACC_INT_W = 17;

  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VOLT,
    ST_MUL1,
    ST_ADD1,
    ST_MUL2,
    ST_ADD2,
    ST_MUL3,
    ST_ADD3,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    STEP_B,
    STEP_C,
    STEP_D
  } step_t;

  typedef struct packed {
    logic  load_filt;
    logic  load_volt;
    logic  mul;
    logic  add;
    step_t step;
    logic  write_out;
  } dp_cmd_t;

  typedef struct packed {
    logic in_poly;
  } dp_status_t;

endpackage

### sv/bcg_ctrl.sv
module bcg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  output logic                result_valid,
  input  logic                result_ready,
  input  bcg_pkg::dp_status_t status,
  output bcg_pkg::dp_cmd_t    cmd
);

  bcg_pkg::state_t state;
  bcg_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bcg_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.write_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bcg_pkg::ST_IDLE: if (sample_valid) state_next = bcg_pkg::ST_VOLT;
      bcg_pkg::ST_VOLT: begin
        state_next = status.in_poly ? bcg_pkg::ST_MUL1 : bcg_pkg::ST_DONE;
      end
      bcg_pkg::ST_MUL1: state_next = bcg_pkg::ST_ADD1;
      bcg_pkg::ST_ADD1: state_next = bcg_pkg::ST_MUL2;
      bcg_pkg::ST_MUL2: state_next = bcg_pkg::ST_ADD2;
      bcg_pkg::ST_ADD2: state_next = bcg_pkg::ST_MUL3;
      bcg_pkg::ST_MUL3: state_next = bcg_pkg::ST_ADD3;
      bcg_pkg::ST_ADD3: state_next = bcg_pkg::ST_DONE;
      bcg_pkg::ST_DONE: if (out_free) state_next = bcg_pkg::ST_IDLE;
      default:          state_next = bcg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sample_ready  = 1'b0;
    cmd.load_filt = 1'b0;
    cmd.load_volt = 1'b0;
    cmd.mul       = 1'b0;
    cmd.add       = 1'b0;
    cmd.step      = bcg_pkg::STEP_B;
    cmd.write_out = 1'b0;
    case (state)
      bcg_pkg::ST_IDLE: begin
        sample_ready  = 1'b1;
        cmd.load_filt = sample_valid;
      end
      bcg_pkg::ST_VOLT: cmd.load_volt = 1'b1;
      bcg_pkg::ST_MUL1,
      bcg_pkg::ST_MUL2,
      bcg_pkg::ST_MUL3: cmd.mul = 1'b1;
      bcg_pkg::ST_ADD1: begin
        cmd.add  = 1'b1;
        cmd.step = bcg_pkg::STEP_B;
      end
      bcg_pkg::ST_ADD2: begin
        cmd.add  = 1'b1;
        cmd.step = bcg_pkg::STEP_C;
      end
      bcg_pkg::ST_ADD3: begin
        cmd.add  = 1'b1;
        cmd.step = bcg_pkg::STEP_D;
      end
      bcg_pkg::ST_DONE: cmd.write_out = out_free;
      default: ;
    endcase
  end

endmodule

### sv/bcg_datapath.sv
module bcg_datapath #(
  parameter int unsigned VOLT_FRAC_BITS = bcg_pkg::VOLT_FRAC_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = bcg_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bcg_pkg::dp_cmd_t            cmd,
  output bcg_pkg::dp_status_t         status,
  input  logic [bcg_pkg::VOLT_W-1:0]  sample_voltage,
  output logic [bcg_pkg::PCT_W-1:0]   charge_percent,
  output logic [bcg_pkg::VOLT_W-1:0]  smoothed_voltage
);

  localparam int unsigned VW      = bcg_pkg::VOLT_W;
  localparam int unsigned FW      = bcg_pkg::FILT_W;
  localparam int unsigned FPROD_W = bcg_pkg::FILT_W + bcg_pkg::RECIP_W;
  localparam int unsigned W       = COEF_FRAC_BITS + bcg_pkg::ACC_INT_W;
  localparam int unsigned P       = W + VW + 1;
  localparam int unsigned IW      = W - COEF_FRAC_BITS;

  localparam logic [VW-1:0] PREV_RESET =
    VW'(((64'd224 << VOLT_FRAC_BITS) + 64'd5) / 64'd10);

  localparam logic [31:0] TH_LO  = 32'(64'd39 << VOLT_FRAC_BITS);
  localparam logic [31:0] TH_MID = 32'(64'd219 << VOLT_FRAC_BITS);
  localparam logic [31:0] TH_HI  = 32'(64'd51 << VOLT_FRAC_BITS);

  // Lower cubic (below 21.9 V)
  localparam logic signed [W-1:0] A1 =
    W'(((64'd5664 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic signed [W-1:0] B1 =
    W'(((64'd3386 << COEF_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic signed [W-1:0] C1 =
    W'(((64'd6765 << COEF_FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic signed [W-1:0] D1 = W'(64'd4517 << COEF_FRAC_BITS);
  // Upper cubic (21.9 V and up)
  localparam logic signed [W-1:0] A2 =
    W'(((64'd2269 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic signed [W-1:0] B2 =
    W'(((64'd1654 << COEF_FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic signed [W-1:0] C2 = W'(64'd4034 << COEF_FRAC_BITS);
  localparam logic signed [W-1:0] D2 = W'(64'd32840 << COEF_FRAC_BITS);

  logic [VW-1:0]         prev;
  logic [FW-1:0]         filt_sum;
  logic [FPROD_W-1:0]    fprod;
  logic [VW-1:0]         v;
  logic                  below_lo;
  logic                  below_mid;
  logic                  at_hi;
  logic [VW-1:0]         vreg;
  logic                  upper;
  logic                  in_poly;
  logic                  hi_sat;
  logic signed [W-1:0]   acc;
  logic signed [P-1:0]   prod;
  logic signed [P-1:0]   prod_sh;
  logic signed [VW:0]    vs;
  logic signed [W-1:0]   coef;
  logic [IW-1:0]         ipart;
  logic [bcg_pkg::PCT_W-1:0] pct;

  assign filt_sum = FW'(3) * FW'(sample_voltage) + FW'(2) * FW'(prev) + FW'(2);

  assign v         = fprod[bcg_pkg::FILT_SHIFT +: VW];
  assign below_lo  = (32'(v) << 1) < TH_LO;
  assign below_mid = (32'(v) * 32'd10) < TH_MID;
  assign at_hi     = (32'(v) << 1) >= TH_HI;
  assign status.in_poly = !below_lo && !at_hi;

  assign vs      = $signed({1'b0, vreg});
  assign prod_sh = prod >>> VOLT_FRAC_BITS;

  always_comb begin
    case (cmd.step)
      bcg_pkg::STEP_B: coef = upper ? -B2 : -B1;
      bcg_pkg::STEP_C: coef = upper ? C2 : C1;
      bcg_pkg::STEP_D: coef = upper ? -D2 : -D1;
      default:         coef = '0;
    endcase
  end

  assign ipart = acc[W-1:COEF_FRAC_BITS];

  always_comb begin
    if (!in_poly) begin
      pct = hi_sat ? bcg_pkg::PCT_MAX : '0;
    end else if (acc <= 0) begin
      pct = '0;
    end else if (ipart > IW'(bcg_pkg::PCT_MAX)) begin
      pct = bcg_pkg::PCT_MAX;
    end else begin
      pct = ipart[bcg_pkg::PCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= PREV_RESET;
    end else if (cmd.load_volt) begin
      prev <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_filt) begin
      fprod <= FPROD_W'(filt_sum) * FPROD_W'(bcg_pkg::FILT_RECIP);
    end
    if (cmd.load_volt) begin
      vreg    <= v;
      upper   <= !below_mid;
      in_poly <= status.in_poly;
      hi_sat  <= at_hi;
      acc     <= below_mid ? A1 : A2;
    end
    if (cmd.mul) begin
      prod <= P'(acc) * P'(vs);
    end
    if (cmd.add) begin
      acc <= $signed(prod_sh[W-1:0]) + coef;
    end
    if (cmd.write_out) begin
      charge_percent   <= pct;
      smoothed_voltage <= vreg;
    end
  end

endmodule

### sv/battery_charge_gauge_top.sv
// Battery charge gauge. Each sample item is smoothed (0.6 sample + 0.4 previous,
// previous starting at 22.4 V) and the smoothed voltage is mapped to a charge
// percentage: 0 below 19.5 V, 100 at or above 25.5 V, a cubic in between (split
// at 21.9 V), truncated and saturated to 0..100. One result item per sample.
// The result is registered after the filter and threshold check and, when the
// cubic is evaluated, three Horner steps through one shared multiplier, each a
// multiply state then an add state; when the voltage lies outside the cubic range
// the threshold check leads straight to the output step. The next sample can be
// accepted in the cycle after the result is registered. A new sample is taken
// while the previous result still waits in the output register; the block then
// holds in its last step until that register is free.
module battery_charge_gauge_top #(
  parameter int unsigned VOLT_FRAC_BITS = bcg_pkg::VOLT_FRAC_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = bcg_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  logic [bcg_pkg::VOLT_W-1:0]  sample_voltage,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [bcg_pkg::PCT_W-1:0]   charge_percent,
  output logic [bcg_pkg::VOLT_W-1:0]  smoothed_voltage
);

  bcg_pkg::dp_cmd_t    cmd;
  bcg_pkg::dp_status_t status;

  bcg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  bcg_datapath #(
    .VOLT_FRAC_BITS (VOLT_FRAC_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .sample_voltage   (sample_voltage),
    .charge_percent   (charge_percent),
    .smoothed_voltage (smoothed_voltage)
  );

endmodule

### sv/bcg_checker.sv
module bcg_checker #(
  parameter int unsigned VOLT_FRAC_BITS = bcg_pkg::VOLT_FRAC_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        sample_valid,
  input logic                        sample_ready,
  input logic [bcg_pkg::VOLT_W-1:0]  sample_voltage,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic [bcg_pkg::PCT_W-1:0]   charge_percent,
  input logic [bcg_pkg::VOLT_W-1:0]  smoothed_voltage
);

  localparam logic [31:0] TH_LO = 32'(64'd39 << VOLT_FRAC_BITS);
  localparam logic [31:0] TH_HI = 32'(64'd51 << VOLT_FRAC_BITS);

  logic [31:0] v2;
  assign v2 = 32'(smoothed_voltage) << 1;

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(charge_percent) && $stable(smoothed_voltage))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample taken while previous item in work");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> charge_percent <= bcg_pkg::PCT_MAX)
    else $error("charge percent above 100");

  a_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (v2 >= TH_LO || charge_percent == '0) &&
                     (v2 < TH_HI || charge_percent == bcg_pkg::PCT_MAX))
    else $error("charge percent wrong outside cubic range");

endmodule

bind battery_charge_gauge_top bcg_checker #(.VOLT_FRAC_BITS(VOLT_FRAC_BITS)) u_chk (.*);

### tb/battery_charge_gauge_top_tb.sv
module battery_charge_gauge_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VOLT_W = bcg_pkg::VOLT_W;
  localparam int unsigned PCT_W  = bcg_pkg::PCT_W;
  localparam logic [PCT_W-1:0] PCT_MAX = bcg_pkg::PCT_MAX;

  localparam int unsigned VF = bcg_pkg::VOLT_FRAC_BITS_DEF;
  localparam int unsigned CF = bcg_pkg::COEF_FRAC_BITS_DEF;
  localparam longint ONE_VOLT = longint'(1) << VF;
  localparam longint VOLT_MAX = (longint'(1) << VOLT_W) - 1;

  localparam longint EMPTY_EDGE = (39 * ONE_VOLT) / 2;
  localparam longint SPLIT_EDGE = (219 * ONE_VOLT + 9) / 10;
  localparam longint FULL_EDGE  = (51 * ONE_VOLT) / 2;
  localparam longint RESET_VOLT = (224 * ONE_VOLT + 5) / 10;

  localparam int N_RANDOM    = 600;
  localparam int N_DIRECTED  = 23;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 32;
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 400;

  function automatic longint coef_q(input longint num, input longint den);
    return ((num << CF) + den / 2) / den;
  endfunction

  localparam longint LOW_A  = coef_q(5664, 10000);
  localparam longint LOW_B  = coef_q(3386, 100);
  localparam longint LOW_C  = coef_q(6765, 10);
  localparam longint LOW_D  = coef_q(4517, 1);
  localparam longint HIGH_A = coef_q(2269, 1000);
  localparam longint HIGH_B = coef_q(1654, 10);
  localparam longint HIGH_C = coef_q(4034, 1);
  localparam longint HIGH_D = coef_q(32840, 1);

  typedef struct packed {
    logic [PCT_W-1:0]  pct;
    logic [VOLT_W-1:0] volt;
  } gauge_result_t;

  typedef enum logic {
    DRIVE_RAW,
    DRIVE_TARGET
  } drive_kind_t;

  typedef struct packed {
    drive_kind_t       kind;
    logic [VOLT_W-1:0] value;
    logic              typed;
    gauge_result_t     result;
  } stim_row_t;

  typedef enum logic [1:0] {
    TAKE_ALWAYS,
    TAKE_COIN,
    TAKE_PERIODIC,
    TAKE_SPARSE
  } take_mode_t;

  localparam gauge_result_t NO_RESULT = '0;

  // raw rows drive the value; target rows drive a sample that lands the filter on the value
  localparam stim_row_t DIR_TABLE [N_DIRECTED] = '{
    '{DRIVE_RAW,    VOLT_W'(0),              1'b1, '{7'd0, 15'd9175}},
    '{DRIVE_RAW,    VOLT_W'(0),              1'b1, '{7'd0, 15'd3670}},
    '{DRIVE_RAW,    VOLT_W'(VOLT_MAX),       1'b0, NO_RESULT},
    '{DRIVE_RAW,    VOLT_W'(VOLT_MAX),       1'b1, '{PCT_MAX, 15'd28111}},
    '{DRIVE_RAW,    VOLT_W'(VOLT_MAX),       1'b1, '{PCT_MAX, 15'd30905}},
    '{DRIVE_RAW,    VOLT_W'(VOLT_MAX),       1'b1, '{PCT_MAX, 15'd32022}},
    '{DRIVE_TARGET, VOLT_W'(FULL_EDGE),      1'b1, '{PCT_MAX, VOLT_W'(FULL_EDGE)}},
    '{DRIVE_TARGET, VOLT_W'(FULL_EDGE - 1),  1'b0, NO_RESULT},
    '{DRIVE_TARGET, VOLT_W'(SPLIT_EDGE),     1'b0, NO_RESULT},
    '{DRIVE_TARGET, VOLT_W'(SPLIT_EDGE - 1), 1'b0, NO_RESULT},
    '{DRIVE_TARGET, VOLT_W'(EMPTY_EDGE),     1'b0, NO_RESULT},
    '{DRIVE_TARGET, VOLT_W'(EMPTY_EDGE - 1), 1'b1, '{7'd0, VOLT_W'(EMPTY_EDGE - 1)}},
    '{DRIVE_TARGET, VOLT_W'(20500),          1'b0, NO_RESULT},
    '{DRIVE_TARGET, VOLT_W'(21000),          1'b0, NO_RESULT},
    '{DRIVE_TARGET, VOLT_W'(21500),          1'b0, NO_RESULT},
    '{DRIVE_TARGET, VOLT_W'(22000),          1'b0, NO_RESULT},
    '{DRIVE_TARGET, VOLT_W'(23000),          1'b0, NO_RESULT},
    '{DRIVE_TARGET, VOLT_W'(24000),          1'b0, NO_RESULT},
    '{DRIVE_TARGET, VOLT_W'(25000),          1'b0, NO_RESULT},
    '{DRIVE_TARGET, VOLT_W'(25800),          1'b0, NO_RESULT},
    '{DRIVE_RAW,    VOLT_W'(16384),          1'b0, NO_RESULT},
    '{DRIVE_RAW,    VOLT_W'(15'h2AAA),       1'b0, NO_RESULT},
    '{DRIVE_RAW,    VOLT_W'(15'h5555),       1'b0, NO_RESULT}
  };

  logic              clk;
  logic              rst;
  logic              sample_valid;
  logic              sample_ready;
  logic [VOLT_W-1:0] sample_voltage;
  logic              result_valid;
  logic              result_ready;
  logic [PCT_W-1:0]  charge_percent;
  logic [VOLT_W-1:0] smoothed_voltage;

  logic [VOLT_W-1:0] held_volt = VOLT_W'(RESET_VOLT);
  gauge_result_t     gauge_expected_q[$];
  int                samples_taken = 0;
  int                burst_left = 0;
  int                n_errors = 0;
  int                cycle_count = 0;

  battery_charge_gauge_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .sample_valid     (sample_valid),
    .sample_ready     (sample_ready),
    .sample_voltage   (sample_voltage),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .charge_percent   (charge_percent),
    .smoothed_voltage (smoothed_voltage)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint horner(input longint a, input longint b, input longint c,
                                    input longint d, input longint v);
    longint acc;
    acc = ((a * v) >>> VF) - b;
    acc = ((acc * v) >>> VF) + c;
    return ((acc * v) >>> VF) - d;
  endfunction

  function automatic gauge_result_t gauge_predict(input logic [VOLT_W-1:0] s,
                                                  input logic [VOLT_W-1:0] prev);
    longint        v;
    longint        acc;
    gauge_result_t r;
    v = (3 * longint'(s) + 2 * longint'(prev) + 2) / 5;
    r.volt = VOLT_W'(v);
    if (2 * v < 39 * ONE_VOLT) begin
      r.pct = '0;
    end else if (2 * v >= 51 * ONE_VOLT) begin
      r.pct = PCT_MAX;
    end else begin
      if (10 * v < 219 * ONE_VOLT) begin
        acc = horner(LOW_A, LOW_B, LOW_C, LOW_D, v);
      end else begin
        acc = horner(HIGH_A, HIGH_B, HIGH_C, HIGH_D, v);
      end
      if (acc <= 0) begin
        r.pct = '0;
      end else if ((acc >>> CF) > longint'(PCT_MAX)) begin
        r.pct = PCT_MAX;
      end else begin
        r.pct = PCT_W'(acc >>> CF);
      end
    end
    return r;
  endfunction

  // sample that puts the smoothed voltage exactly on target, given the held value
  function automatic logic [VOLT_W-1:0] aim_sample(input longint target);
    longint num;
    num = 5 * target - 2 * longint'(held_volt) - 2;
    if (num <= 0) return '0;
    if ((num + 2) / 3 > VOLT_MAX) return VOLT_W'(VOLT_MAX);
    return VOLT_W'((num + 2) / 3);
  endfunction

  task automatic send_sample(input logic [VOLT_W-1:0] s, input logic typed,
                             input gauge_result_t typed_res);
    int            gap;
    gauge_result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        sample_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    sample_valid   <= 1'b1;
    sample_voltage <= s;
    do @(posedge clk); while (!sample_ready);
    r = gauge_predict(s, held_volt);
    held_volt = r.volt;
    gauge_expected_q.push_back(typed ? typed_res : r);
    samples_taken++;
  endtask

  task automatic check_result(input logic [PCT_W-1:0] pct, input logic [VOLT_W-1:0] volt);
    gauge_result_t want;
    if (gauge_expected_q.size() == 0) begin
      $display("%0t: unexpected item, charge_percent %0d smoothed_voltage %0d",
               $time, pct, volt);
      n_errors++;
      return;
    end
    want = gauge_expected_q.pop_front();
    if (pct !== want.pct) begin
      $display("%0t: charge_percent expected %0d actual %0d", $time, want.pct, pct);
      n_errors++;
    end
    if (volt !== want.volt) begin
      $display("%0t: smoothed_voltage expected %0d actual %0d", $time, want.volt, volt);
      n_errors++;
    end
  endtask

  initial begin : result_side
    take_mode_t mode;
    int         mode_left;
    int         hold_left;
    int         tick;
    logic       hold_done;
    result_ready <= 1'b0;
    mode = TAKE_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (result_valid && result_ready) check_result(charge_percent, smoothed_voltage);
      if (!hold_done && samples_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = take_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 200);
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        case (mode)
          TAKE_ALWAYS:   result_ready <= 1'b1;
          TAKE_COIN:     result_ready <= 1'($urandom_range(0, 1));
          TAKE_PERIODIC: result_ready <= (tick % 7) < 4;
          default:       result_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("battery_charge_gauge_top_tb: errors");
    $finish;
  end

  initial begin : stimulus
    logic [VOLT_W-1:0] s;
    longint            target;
    int                pick;
    int                run;
    int                n_sent;
    rst            <= 1'b1;
    sample_valid   <= 1'b0;
    sample_voltage <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIR_TABLE[i].kind == DRIVE_TARGET) begin
        s = aim_sample(longint'(DIR_TABLE[i].value));
      end else begin
        s = DIR_TABLE[i].value;
      end
      send_sample(s, DIR_TABLE[i].typed, DIR_TABLE[i].result);
    end

    n_sent = 0;
    while (n_sent < N_RANDOM) begin
      pick = $urandom_range(0, 99);
      run = 1;
      if (pick < 55) begin
        s = VOLT_W'($urandom_range(19000, 27000));
      end else if (pick < 70) begin
        s = VOLT_W'($urandom_range(0, int'(VOLT_MAX)));
      end else if (pick < 78) begin
        s = $urandom_range(0, 1) ? VOLT_W'(VOLT_MAX) : VOLT_W'(0);
      end else if (pick < 90) begin
        case ($urandom_range(0, 2))
          0:       target = EMPTY_EDGE;
          1:       target = SPLIT_EDGE;
          default: target = FULL_EDGE;
        endcase
        s = aim_sample(target + longint'($urandom_range(0, 6)) - 3);
      end else begin
        // repeated sample: filter settles onto it
        s = VOLT_W'($urandom_range(19500, 26500));
        run = $urandom_range(3, 10);
      end
      repeat (run) send_sample(s, 1'b0, NO_RESULT);
      n_sent += run;
    end
    sample_valid <= 1'b0;

    while (gauge_expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("battery_charge_gauge_top_tb: clean");
    end else begin
      $display("battery_charge_gauge_top_tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
sv/bcg_pkg.sv
sv/bcg_ctrl.sv
sv/bcg_datapath.sv
sv/battery_charge_gauge_top.sv
sv/bcg_checker.sv
tb/battery_charge_gauge_top_tb.sv
